/* rtl/circ_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package circ_pkg;

	// Operation codes carried by an input item.
	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_DRAW  = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_SCAN,
		ST_DRAIN,
		ST_READ,
		ST_DONE
	} state_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_WIDTH      = 2'd0;
	localparam logic [1:0] CFG_HEIGHT     = 2'd1;
	localparam logic [1:0] CFG_BACKGROUND = 2'd2;

	// Shape kind bytes.
	localparam logic [7:0] KIND_FILLED  = 8'd67;
	localparam logic [7:0] KIND_OUTLINE = 8'd99;

	// Fixed point format of coordinates.
	localparam int FRAC_BITS = 8;
	localparam int ONE_Q8    = 1 << FRAC_BITS;
	localparam int ONE_SQ    = 1 << (2 * FRAC_BITS);

	// Field widths.
	localparam int COORD_W = 24;
	localparam int CFG_W   = 9;
	localparam int BYTE_W  = 8;

	// Setup steps of the shared squaring unit.
	localparam logic [2:0] STEP_CX    = 3'd0;
	localparam logic [2:0] STEP_CY    = 3'd1;
	localparam logic [2:0] STEP_RAD   = 3'd2;
	localparam logic [2:0] STEP_INNER = 3'd3;
	localparam logic [2:0] STEP_LAST  = 3'd4;

endpackage

`default_nettype wire

/* rtl/circle_raster_canvas_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Signals
// -------   ---------  -------------------------------------------------------
// input     in         in_valid, in_stall, operation .. read_row
// output    out        out_valid, out_stall, status, pixel_byte
// config    in         cfg_we, cfg_index, cfg_data
//
// A clear, or a draw of a known kind, scans the W*H pixels, W and H being
// the columns and rows in use: the scan visits one pixel per cycle through
// the single write port of the canvas memory. The block takes one item at a
// time and holds in_stall high until the result sits in the output register.
// Reset restores the configuration registers; the canvas itself holds
// garbage until cleared.
module circle_raster_canvas_unit
	import circ_pkg::*;
#(
	parameter int MAX_COLUMNS = 256,
	parameter int MAX_ROWS    = 256
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_stall,
	input  wire  [1:0]                operation,
	input  wire  [BYTE_W-1:0]         shape_kind,
	input  wire  signed [COORD_W-1:0] center_x,
	input  wire  signed [COORD_W-1:0] center_y,
	input  wire  signed [COORD_W-1:0] radius,
	input  wire  [BYTE_W-1:0]         circle_paint,
	input  wire  [BYTE_W-1:0]         read_column,
	input  wire  [BYTE_W-1:0]         read_row,
	output logic                      out_valid,
	input  wire                       out_stall,
	output logic                      status,
	output logic [BYTE_W-1:0]         pixel_byte,
	input  wire                       cfg_we,
	input  wire  [1:0]                cfg_index,
	input  wire  [CFG_W-1:0]          cfg_data
);

	localparam int DEPTH   = MAX_COLUMNS * MAX_ROWS;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int COL_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CNTC_W  = $clog2(MAX_COLUMNS + 1);
	localparam int CNTR_W  = $clog2(MAX_ROWS + 1);
	localparam int CMPC_W  = (CNTC_W > CFG_W) ? CNTC_W : CFG_W;
	localparam int CMPR_W  = (CNTR_W > CFG_W) ? CNTR_W : CFG_W;
	localparam int MUL_W   = COORD_W + 1;
	localparam int DX_W    = COORD_W + 2;
	localparam int SQ_W    = 2 * DX_W;

	// Control state.
	state_t state_q, state_d;
	logic   out_load_c;
	logic   in_accept_c;
	logic   valid_s1;

	// Configuration registers.
	logic [CFG_W-1:0]  width_q;
	logic [CFG_W-1:0]  height_q;
	logic [BYTE_W-1:0] background_q;

	// Item registers.
	op_t                      op_q;
	logic                     outline_q;
	logic                     small_q;
	logic                     kind_err_q;
	logic signed [COORD_W-1:0] cx_q;
	logic signed [COORD_W-1:0] cy_q;
	logic signed [COORD_W-1:0] rad_q;
	logic [BYTE_W-1:0]        paint_q;
	logic [BYTE_W-1:0]        rd_col_q;
	logic [BYTE_W-1:0]        rd_row_q;

	// Shared squaring unit and setup results.
	logic [2:0]               step_q;
	logic signed [MUL_W-1:0]  mul_a_c;
	logic signed [2*MUL_W-1:0] mult_s1;
	logic [SQ_W-1:0]          cxsq_q;
	logic [SQ_W-1:0]          rsq_q;
	logic [SQ_W-1:0]          innersq_q;

	// Scan counters and incremental distances.
	logic [COL_W-1:0]         col_q;
	logic [ROW_W-1:0]         row_q;
	logic [ADDR_W-1:0]        row_base_q;
	logic signed [DX_W-1:0]   dx_q;
	logic signed [DX_W-1:0]   dy_q;
	logic [SQ_W-1:0]          dxsq_q;
	logic [SQ_W-1:0]          dysq_q;
	logic [SQ_W-1:0]          dx_ext_c;
	logic [SQ_W-1:0]          dy_ext_c;
	logic                     col_last_c;
	logic                     row_last_c;

	// Pixel stage and canvas memory.
	logic [ADDR_W-1:0]        addr_s1;
	logic [SQ_W:0]            d2_s1;
	logic                     hit_c;
	logic                     wr_en_c;
	logic [BYTE_W-1:0]        wr_data_c;
	logic [BYTE_W-1:0]        canvas_mem [DEPTH];
	logic [ADDR_W-1:0]        rd_addr_c;
	logic [BYTE_W-1:0]        rd_data_q;
	logic                     rd_in_range_q;

	// Result register.
	logic                     out_valid_q;
	logic                     status_q;
	logic [BYTE_W-1:0]        pixel_q;

	// Columns and rows in use, saturated to the store size.
	logic [CMPC_W-1:0] used_cols_c;
	logic [CMPR_W-1:0] used_rows_c;
	logic              empty_c;
	logic              kind_ok_c;

	assign used_cols_c = (CMPC_W'(width_q) > CMPC_W'(MAX_COLUMNS)) ?
		CMPC_W'(MAX_COLUMNS) : CMPC_W'(width_q);
	assign used_rows_c = (CMPR_W'(height_q) > CMPR_W'(MAX_ROWS)) ?
		CMPR_W'(MAX_ROWS) : CMPR_W'(height_q);
	assign empty_c     = (used_cols_c == '0) || (used_rows_c == '0);
	assign kind_ok_c   = (shape_kind == KIND_FILLED) || (shape_kind == KIND_OUTLINE);

	assign in_stall    = (state_q != ST_IDLE);
	assign in_accept_c = in_valid && !in_stall;
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign pixel_byte  = pixel_q;

	assign col_last_c = (CMPC_W'(col_q) == (used_cols_c - CMPC_W'(1)));
	assign row_last_c = (CMPR_W'(row_q) == (used_rows_c - CMPR_W'(1)));

	// Next state of the sequencer.
	always_comb begin
		state_d    = state_q;
		out_load_c = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (op_t'(operation))
						OP_CLEAR: state_d = empty_c ? ST_DONE : ST_SCAN;
						OP_DRAW:  state_d = (kind_ok_c && !empty_c) ? ST_SETUP : ST_DONE;
						OP_READ:  state_d = ST_READ;
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_SETUP: begin
				if (step_q == STEP_LAST) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (col_last_c && row_last_c) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_DONE;
			ST_READ:  state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load_c = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			width_q      <= CFG_W'(256);
			height_q     <= CFG_W'(256);
			background_q <= BYTE_W'(32);
		end else begin
			state_q  <= state_d;
			valid_s1 <= (state_q == ST_SCAN);
			if (out_load_c) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_WIDTH:      width_q      <= cfg_data;
					CFG_HEIGHT:     height_q     <= cfg_data;
					CFG_BACKGROUND: background_q <= cfg_data[BYTE_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Operand of the shared squaring unit for each setup step.
	always_comb begin
		unique case (step_q)
			STEP_CX:    mul_a_c = MUL_W'(cx_q);
			STEP_CY:    mul_a_c = MUL_W'(cy_q);
			STEP_RAD:   mul_a_c = MUL_W'(rad_q);
			STEP_INNER: mul_a_c = MUL_W'(rad_q) - MUL_W'(ONE_Q8);
			default:    mul_a_c = '0;
		endcase
	end

	// Sign-extended offsets for the incremental square updates.
	assign dx_ext_c = SQ_W'(dx_q);
	assign dy_ext_c = SQ_W'(dy_q);

	// Item capture, setup squares and the pixel scan.
	always_ff @(posedge clk) begin
		if (in_accept_c) begin
			op_q       <= op_t'(operation);
			outline_q  <= (shape_kind == KIND_OUTLINE);
			small_q    <= (radius < COORD_W'(ONE_Q8));
			kind_err_q <= (op_t'(operation) == OP_DRAW) && !kind_ok_c;
			cx_q       <= center_x;
			cy_q       <= center_y;
			rad_q      <= radius;
			paint_q    <= circle_paint;
			rd_col_q   <= read_column;
			rd_row_q   <= read_row;
			col_q      <= '0;
			row_q      <= '0;
			row_base_q <= '0;
			dx_q       <= -DX_W'(center_x);
			dy_q       <= -DX_W'(center_y);
			step_q     <= '0;
		end

		// One square per cycle; each product passes through mult_s1 and is stored at the next step.
		if (state_q == ST_SETUP) begin
			step_q  <= step_q + 3'd1;
			mult_s1 <= mul_a_c * mul_a_c;
			unique case (step_q)
				STEP_CY: begin
					cxsq_q <= SQ_W'($unsigned(mult_s1));
					dxsq_q <= SQ_W'($unsigned(mult_s1));
				end
				STEP_RAD:   dysq_q    <= SQ_W'($unsigned(mult_s1));
				STEP_INNER: rsq_q     <= SQ_W'($unsigned(mult_s1));
				STEP_LAST:  innersq_q <= SQ_W'($unsigned(mult_s1));
				default: ;
			endcase
		end

		// Scan one pixel per cycle, updating squares by (d+1)^2 = d^2 + 2d + 1.
		if (state_q == ST_SCAN) begin
			addr_s1 <= row_base_q + ADDR_W'(col_q);
			d2_s1   <= {1'b0, dxsq_q} + {1'b0, dysq_q};
			if (col_last_c) begin
				col_q  <= '0;
				dx_q   <= -DX_W'(cx_q);
				dxsq_q <= cxsq_q;
				if (!row_last_c) begin
					row_q      <= row_q + ROW_W'(1);
					row_base_q <= row_base_q + ADDR_W'(MAX_COLUMNS);
					dy_q       <= dy_q + DX_W'(ONE_Q8);
					dysq_q     <= dysq_q + (dy_ext_c << (FRAC_BITS + 1)) + SQ_W'(ONE_SQ);
				end
			end else begin
				col_q  <= col_q + COL_W'(1);
				dx_q   <= dx_q + DX_W'(ONE_Q8);
				dxsq_q <= dxsq_q + (dx_ext_c << (FRAC_BITS + 1)) + SQ_W'(ONE_SQ);
			end
		end

		// Read range check follows the captured coordinates.
		rd_in_range_q <= (CMPC_W'(rd_col_q) < used_cols_c) &&
			(CMPR_W'(rd_row_q) < used_rows_c);

		// Result register.
		if (out_load_c) begin
			status_q <= kind_err_q;
			pixel_q  <= ((op_q == OP_READ) && rd_in_range_q) ? rd_data_q : '0;
		end
	end

	// Paint decision for the pixel in the first stage.
	always_comb begin
		hit_c = (d2_s1 <= {1'b0, rsq_q});
		if (outline_q) begin
			hit_c = hit_c && (small_q || (d2_s1 > {1'b0, innersq_q}));
		end
	end

	assign wr_en_c   = valid_s1 && ((op_q == OP_CLEAR) || hit_c);
	assign wr_data_c = (op_q == OP_CLEAR) ? background_q : paint_q;
	assign rd_addr_c = ADDR_W'(32'(rd_row_q) * MAX_COLUMNS + 32'(rd_col_q));

	// Canvas memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en_c) begin
			canvas_mem[addr_s1] <= wr_data_c;
		end
		rd_data_q <= canvas_mem[rd_addr_c];
	end

`ifndef SYNTH
	// The canvas is written only by the scan and its last pipeline stage.
	a_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en_c |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("canvas written outside the scan");

	// A result appears only when the sequencer finishes an item.
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result raised outside the done state");

	// An item with an unknown kind never reaches the scan.
	a_no_scan_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !kind_err_q)
		else $error("scan started for an unknown kind");
`endif

endmodule

`default_nettype wire
